/* rtl/trc_pkg.sv */
// ----------------------------------------------------------------------------
// trc_pkg: shared types and constants for the trace ring
// Sizes of the ring, item and result transfer structs, slot layout, FSM states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

  // Ring geometry and stored field widths
  localparam int unsigned DEPTH      = 32;
  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned DESC_WIDTH = 16;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths on the ports
  localparam int unsigned DESC_FIELD_W = 16;
  localparam int unsigned DATA_FIELD_W = 64;
  localparam int unsigned REP_W        = 16;
  localparam int unsigned TOTAL_W      = 32;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DESC_WIDTH-1:0] desc_t;
  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REP_W-1:0]      rep_t;
  typedef logic [TOTAL_W-1:0]    total_t;

  // Item kinds
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_DUMP   = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [DESC_FIELD_W-1:0] descriptor_id;
    logic [DATA_FIELD_W-1:0] data_value;
  } trace_in_t;

  typedef struct packed {
    logic [DESC_FIELD_W-1:0] out_descriptor;
    logic [DATA_FIELD_W-1:0] out_data;
    logic [REP_W-1:0]        repeat_delta;
    logic                    last_of_dump;
  } trace_out_t;

  // One ring slot
  typedef struct packed {
    desc_t desc;
    data_t data;
    rep_t  repeats;
  } slot_t;

  // Write request into the slot store
  typedef struct packed {
    logic  en;
    idx_t  addr;
    slot_t slot;
  } slot_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_DUMP
  } state_e;

  // Advance a ring index with wrap
  function automatic idx_t idx_next(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/trc_slot_mem.sv */
// ----------------------------------------------------------------------------
// trc_slot_mem: slot store of the trace ring
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trc_slot_mem (
  input  wire               clk_i,
  input  trc_pkg::slot_wr_t wr_i,
  input  trc_pkg::idx_t     rd_addr_i,
  output trc_pkg::slot_t    rd_data_o
);

  trc_pkg::slot_t mem_q [trc_pkg::DEPTH];
  trc_pkg::slot_t rd_data_q;

  // Write the slot on request
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.slot;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* rtl/trace_ring_repeat_compress.sv */
// ----------------------------------------------------------------------------
// trace_ring_repeat_compress: debug trace ring with repeat folding
// Records trace points into a ring of slots and dumps new ones on request.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a clock edge with start high and busy low. A record
//   item (kind 0) folds into the newest slot when its descriptor repeats, or
//   opens the next slot. A dump item (kind 1) emits every slot with new
//   repeats since the previous dump, at most DEPTH of them, oldest first.
//   Each result is on result_o for one cycle with result_valid_o high; the
//   final result of a dump carries last_of_dump. The receiver cannot stall.
// Operation:
//   A record reads the newest slot at the transfer edge, then does the
//   descriptor compare and slot write through the store's single write port.
//   A dump streams one slot a cycle out of the store, and one result is
//   held back until the next nonzero slot or the end of the scan decides
//   whether it is last. A dump of an empty ring emits no result and busy
//   stays low. busy stays high while an item is in work.
// Reset:
//   Resets the counters and the sequencer; slot contents stay undefined
//   until written, and no slot's contents are used before it is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trace_ring_repeat_compress (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  trc_pkg::trace_in_t  item_i,
  output logic                result_valid_o,
  output trc_pkg::trace_out_t result_o
);

  trc_pkg::state_e     state_q, state_d;
  trc_pkg::total_t     rec_total_q, rec_total_d;
  trc_pkg::total_t     dump_total_q, dump_total_d;
  trc_pkg::rep_t       dump_rep_q, dump_rep_d;
  trc_pkg::idx_t       rec_idx_q, rec_idx_d;
  trc_pkg::idx_t       dump_idx_q, dump_idx_d;
  trc_pkg::desc_t      desc_q, desc_d;
  trc_pkg::data_t      data_q, data_d;
  trc_pkg::idx_t       issue_idx_q, issue_idx_d;
  trc_pkg::cnt_t       issue_cnt_q, issue_cnt_d;
  logic                rd_vld_q, rd_vld_d;
  trc_pkg::rep_t       base_q, base_d;
  trc_pkg::rep_t       last_rep_q, last_rep_d;
  logic                pend_vld_q, pend_vld_d;
  trc_pkg::trace_out_t pend_q, pend_d;
  logic                res_vld_q, res_vld_d;
  trc_pkg::trace_out_t res_q, res_d;

  trc_pkg::slot_wr_t   wr;
  trc_pkg::idx_t       rd_addr;
  trc_pkg::slot_t      rd_data;

  logic                accept;
  logic                issue;
  trc_pkg::total_t     diff;
  logic                overrun;
  trc_pkg::rep_t       delta;

  trc_slot_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign accept  = start && !busy;
  assign rd_addr = (state_q == trc_pkg::ST_DUMP) ? issue_idx_q : rec_idx_q;
  assign diff    = rec_total_q - dump_total_q;
  assign overrun = (diff >= trc_pkg::total_t'(trc_pkg::DEPTH));
  assign issue   = (state_q == trc_pkg::ST_DUMP) && (issue_cnt_q != '0);
  assign delta   = rd_data.repeats - base_q;

  // Sequencer: next state, counters and result staging
  always_comb begin
    state_d      = state_q;
    rec_total_d  = rec_total_q;
    dump_total_d = dump_total_q;
    dump_rep_d   = dump_rep_q;
    rec_idx_d    = rec_idx_q;
    dump_idx_d   = dump_idx_q;
    desc_d       = desc_q;
    data_d       = data_q;
    issue_idx_d  = issue_idx_q;
    issue_cnt_d  = issue_cnt_q;
    rd_vld_d     = 1'b0;
    base_d       = base_q;
    last_rep_d   = last_rep_q;
    pend_vld_d   = pend_vld_q;
    pend_d       = pend_q;
    res_vld_d    = 1'b0;
    res_d        = res_q;
    wr           = '0;

    unique case (state_q)
      trc_pkg::ST_IDLE: begin
        if (accept) begin
          if (item_i.kind == trc_pkg::KIND_RECORD) begin
            // Latch the record; the newest slot is read at this edge
            desc_d  = item_i.descriptor_id[trc_pkg::DESC_WIDTH-1:0];
            data_d  = item_i.data_value[trc_pkg::DATA_WIDTH-1:0];
            state_d = trc_pkg::ST_REC;
          end else if (rec_total_q != '0) begin
            // Set up the dump range
            if (overrun) begin
              issue_idx_d = trc_pkg::idx_next(rec_idx_q);
              issue_cnt_d = trc_pkg::cnt_t'(trc_pkg::DEPTH);
              base_d      = '0;
            end else begin
              issue_idx_d = dump_idx_q;
              issue_cnt_d = trc_pkg::cnt_t'(diff) + trc_pkg::cnt_t'(1);
              base_d      = dump_rep_q;
            end
            pend_vld_d = 1'b0;
            state_d    = trc_pkg::ST_DUMP;
          end
        end
      end

      trc_pkg::ST_REC: begin
        // Fold into the newest slot or open the next one
        wr.en        = 1'b1;
        wr.slot.desc = desc_q;
        wr.slot.data = data_q;
        if (rec_total_q == '0) begin
          rec_total_d     = trc_pkg::total_t'(1);
          rec_idx_d       = trc_pkg::idx_next(rec_idx_q);
          wr.slot.repeats = trc_pkg::rep_t'(1);
        end else if (rd_data.desc != desc_q) begin
          rec_total_d     = rec_total_q + trc_pkg::total_t'(1);
          rec_idx_d       = trc_pkg::idx_next(rec_idx_q);
          wr.slot.repeats = trc_pkg::rep_t'(1);
        end else begin
          wr.slot.repeats = rd_data.repeats + trc_pkg::rep_t'(1);
        end
        wr.addr = rec_idx_d;
        state_d = trc_pkg::ST_IDLE;
      end

      trc_pkg::ST_DUMP: begin
        // Stream one slot read per cycle
        if (issue) begin
          issue_idx_d = trc_pkg::idx_next(issue_idx_q);
          issue_cnt_d = issue_cnt_q - trc_pkg::cnt_t'(1);
        end
        rd_vld_d = issue;

        // Hold one result back until the next one or the end decides last
        if (rd_vld_q) begin
          base_d     = '0;
          last_rep_d = rd_data.repeats;
          if (delta != '0) begin
            if (pend_vld_q) begin
              res_vld_d          = 1'b1;
              res_d              = pend_q;
              res_d.last_of_dump = 1'b0;
            end
            pend_vld_d            = 1'b1;
            pend_d.out_descriptor = trc_pkg::DESC_FIELD_W'(rd_data.desc);
            pend_d.out_data       = trc_pkg::DATA_FIELD_W'(rd_data.data);
            pend_d.repeat_delta   = delta;
            pend_d.last_of_dump   = 1'b0;
          end
        end

        // Finish: flush the held result and record the dump point
        if (!issue && !rd_vld_q) begin
          if (pend_vld_q) begin
            res_vld_d          = 1'b1;
            res_d              = pend_q;
            res_d.last_of_dump = 1'b1;
          end
          pend_vld_d   = 1'b0;
          dump_total_d = rec_total_q;
          dump_rep_d   = last_rep_q;
          dump_idx_d   = rec_idx_q;
          state_d      = trc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = trc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= trc_pkg::ST_IDLE;
      rec_total_q  <= '0;
      dump_total_q <= trc_pkg::total_t'(1);
      dump_rep_q   <= '0;
      rec_idx_q    <= '0;
      dump_idx_q   <= trc_pkg::idx_t'(1);
      issue_idx_q  <= '0;
      issue_cnt_q  <= '0;
      rd_vld_q     <= 1'b0;
      base_q       <= '0;
      last_rep_q   <= '0;
      pend_vld_q   <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      rec_total_q  <= rec_total_d;
      dump_total_q <= dump_total_d;
      dump_rep_q   <= dump_rep_d;
      rec_idx_q    <= rec_idx_d;
      dump_idx_q   <= dump_idx_d;
      issue_idx_q  <= issue_idx_d;
      issue_cnt_q  <= issue_cnt_d;
      rd_vld_q     <= rd_vld_d;
      base_q       <= base_d;
      last_rep_q   <= last_rep_d;
      pend_vld_q   <= pend_vld_d;
      res_vld_q    <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    data_q <= data_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != trc_pkg::ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire
